FILE: rtl/prfe_pkg.sv
// prfe_pkg: shared types and constants of the page frame replacement engine.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package prfe_pkg;

  // fixed field widths of the channels and the configuration port
  localparam int PAGE_W     = 16;
  localparam int SLOT_W     = 4;
  localparam int COUNT_W    = 32;
  localparam int USED_W     = 5;
  localparam int POLICY_W   = 2;
  localparam int FC_W       = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'd1;

  // policy codes; the unused code runs as FIFO
  localparam logic [POLICY_W-1:0] POL_FIFO  = 2'd0;
  localparam logic [POLICY_W-1:0] POL_LRU   = 2'd1;
  localparam logic [POLICY_W-1:0] POL_CLOCK = 2'd2;

  localparam logic [FC_W-1:0] FC_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL,
    ST_APPLY
  } state_t;

  typedef enum logic [1:0] {
    KIND_HIT,
    KIND_FILL,
    KIND_FAULT
  } kind_t;

  // broadcast from the controller to every frame cell
  typedef struct packed {
    logic load;       // a beat is taken: capture the tag compare
    logic apply;      // commit the selected action this cycle
    logic write_tag;  // the selected frame takes the new page
  } cell_cmd_t;

  // second-chance search, rippled cell to cell
  typedef struct packed {
    logic found_a;    // free frame seen at or after the hand
    logic found_b;    // free frame seen before the hand
  } clk_chain_t;

  typedef struct packed {
    logic               hit;
    logic               fault;
    logic               written;
    logic [SLOT_W-1:0]  slot;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] fault_count;
    logic [USED_W-1:0]  frames_used;
  } result_t;

endpackage

FILE: rtl/prfe_if.sv
// prfe_if: valid/ready channel interfaces of the page frame replacement engine.
// Depends on prfe_pkg for the field widths and the result type.
interface prfe_in_if;
  logic                          valid;
  logic                          ready;
  logic [prfe_pkg::PAGE_W-1:0]   page_id;

  modport source (output valid, output page_id, input ready);
  modport sink   (input valid, input page_id, output ready);
endinterface

interface prfe_out_if;
  logic                valid;
  logic                ready;
  prfe_pkg::result_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/page_frame_replacement_engine.sv
// page_frame_replacement_engine: FIFO / LRU / CLOCK page frame replacement over a
// row of prfe_cell frames. Depends on prfe_pkg, prfe_if and prfe_cell.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------------
//  in_ch    | in  | valid/ready        | page_id[15:0]
//  out_ch   | out | valid/ready        | hit fault written slot evicted_* count used
//  cfg_*    | in  | cfg_we, no backpr. | cfg_index 0 policy, 1 frame_count
//
// Steps per beat: compare on accept, select, commit. An LRU fault after
//   frame_count was lowered below the filled frames stays in select, stepping
//   the target rank down in the victim search until a frame in range holds it.
// Reset: synchronous, active low; no clearing pass, ranks and used bits reset.
// Stalls: a result waits in the output register; the commit of the next beat
//   holds until that register is free, and a new beat is taken in that cycle.
module page_frame_replacement_engine #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  prfe_in_if.sink                           in_ch,
  prfe_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [prfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prfe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int EW    = (CNT_W > prfe_pkg::FC_W) ? CNT_W : prfe_pkg::FC_W;

  // configuration
  logic [prfe_pkg::POLICY_W-1:0] policy_r, policy_nxt;
  logic [prfe_pkg::FC_W-1:0]     fc_r, fc_nxt;
  logic [EW-1:0]                 fc_w;
  logic [CNT_W-1:0]              eff;

  // control and engine state
  prfe_pkg::state_t              state_r, state_nxt;
  prfe_pkg::kind_t               kind_r, kind_nxt, kind_sel;
  logic [PAGE_BITS-1:0]          page_r, page_nxt, in_page;
  logic [IDX_W-1:0]              hand_r, hand_nxt, hand_eff;
  logic [CNT_W-1:0]              filled_r, filled_nxt;
  logic [prfe_pkg::COUNT_W-1:0]  fault_total_r, fault_total_nxt;
  logic                          seek_r, seek_nxt;
  logic [IDX_W-1:0]              tgt_r, tgt_nxt, tgt;
  logic [FRAMES-1:0]             vict_r, vict_nxt, vict_sel, hand_oh, fill_oh;
  logic [IDX_W-1:0]              vidx_r, vidx_nxt, vidx_sel;
  logic [CNT_W-1:0]              old_rank_r, old_rank_nxt, old_rank_sel;
  logic [FRAMES-1:0]             clr_r, clr_nxt;
  prfe_pkg::result_t             out_r, out_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // cell row
  prfe_pkg::cell_cmd_t           cmd;
  prfe_pkg::clk_chain_t          chain_w [FRAMES+1];
  logic [FRAMES-1:0]             match_vec, cand_vec, clk_sel_vec, clk_clr_vec;
  logic [PAGE_BITS-1:0]          tag_w [FRAMES];
  logic [IDX_W-1:0]              rank_w [FRAMES];
  logic                          any_a, any_b, fwd_hit;

  logic                          hit, full, lru_any, sel_done, is_fault;
  logic                          out_free, apply_go, accept;
  logic [PAGE_BITS-1:0]          ev_page;
  logic [CNT_W-1:0]              vnext;

  // ---------------------------------------------------------------- config
  always_comb begin
    policy_nxt = policy_r;
    fc_nxt     = fc_r;
    if (cfg_we) begin
      unique case (cfg_index)
        prfe_pkg::CFG_POLICY:      policy_nxt = cfg_data[prfe_pkg::POLICY_W-1:0];
        prfe_pkg::CFG_FRAME_COUNT: fc_nxt     = cfg_data[prfe_pkg::FC_W-1:0];
        default: ;
      endcase
    end
  end

  // frame count clamped to 1..FRAMES
  always_comb begin
    fc_w = EW'(fc_r);
    if (fc_w == '0) begin
      eff = CNT_W'(1);
    end else if (fc_w > EW'(FRAMES)) begin
      eff = CNT_W'(FRAMES);
    end else begin
      eff = CNT_W'(fc_w);
    end
  end

  // ------------------------------------------------------------- handshake
  assign out_free = !out_valid_r || out_ch.ready;
  assign apply_go = (state_r == prfe_pkg::ST_APPLY) && out_free;
  assign in_ch.ready = (state_r == prfe_pkg::ST_IDLE) || apply_go;
  assign accept   = in_ch.valid && in_ch.ready;
  assign in_page  = PAGE_BITS'(in_ch.page_id);
  assign fwd_hit  = (page_r == in_page);

  assign cmd.load      = accept;
  assign cmd.apply     = apply_go;
  assign cmd.write_tag = (kind_r != prfe_pkg::KIND_HIT);

  assign hand_eff = (CNT_W'(hand_r) >= eff) ? '0 : hand_r;
  assign tgt      = seek_r ? tgt_r : IDX_W'(filled_r - CNT_W'(1));

  // -------------------------------------------------------------- cell row
  assign chain_w[0] = '0;
  assign any_a = chain_w[FRAMES].found_a;
  assign any_b = chain_w[FRAMES].found_b;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    prfe_cell #(
      .IDX       (g),
      .PAGE_BITS (PAGE_BITS),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .cmp_page  (in_page),
      .wr_page   (page_r),
      .fwd_hit   (fwd_hit),
      .filled    (filled_r),
      .eff       (eff),
      .old_rank  (old_rank_r),
      .hand      (hand_eff),
      .tgt       (tgt),
      .vict      (vict_r[g]),
      .clr       (clr_r[g]),
      .chain_in  (chain_w[g]),
      .any_a     (any_a),
      .chain_out (chain_w[g+1]),
      .match     (match_vec[g]),
      .cand      (cand_vec[g]),
      .clk_sel   (clk_sel_vec[g]),
      .clk_clr   (clk_clr_vec[g]),
      .tag       (tag_w[g]),
      .rank      (rank_w[g])
    );
  end

  // ------------------------------------------------------- victim select
  assign hit     = |match_vec;
  assign full    = filled_r >= eff;
  assign lru_any = |cand_vec;

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      hand_oh[i] = (hand_eff == IDX_W'(i));
      fill_oh[i] = (filled_r == CNT_W'(i));
    end
  end

  always_comb begin
    kind_sel = prfe_pkg::KIND_FAULT;
    vict_sel = hand_oh;
    priority if (hit) begin
      kind_sel = prfe_pkg::KIND_HIT;
      vict_sel = match_vec;
    end else if (!full) begin
      kind_sel = prfe_pkg::KIND_FILL;
      vict_sel = fill_oh;
    end else begin
      unique case (policy_r)
        prfe_pkg::POL_LRU:   vict_sel = cand_vec;
        prfe_pkg::POL_CLOCK: vict_sel = (any_a || any_b) ? clk_sel_vec : hand_oh;
        default:             vict_sel = hand_oh;
      endcase
    end
  end

  assign is_fault = (kind_sel == prfe_pkg::KIND_FAULT);
  // LRU search steps the target rank down until a frame in range holds it
  assign sel_done = !(is_fault && (policy_r == prfe_pkg::POL_LRU) && !lru_any);

  always_comb begin
    vidx_sel     = '0;
    old_rank_sel = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (vict_sel[i]) begin
        vidx_sel     = vidx_sel | IDX_W'(i);
        old_rank_sel = old_rank_sel | CNT_W'(rank_w[i]);
      end
    end
    // a fill ages every resident frame
    if (kind_sel == prfe_pkg::KIND_FILL) begin
      old_rank_sel = CNT_W'(FRAMES);
    end
  end

  // --------------------------------------------------------------- commit
  always_comb begin
    ev_page = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (vict_r[i]) begin
        ev_page = ev_page | tag_w[i];
      end
    end
  end

  assign vnext = CNT_W'(vidx_r) + CNT_W'(1);

  always_comb begin
    state_nxt       = state_r;
    kind_nxt        = kind_r;
    page_nxt        = page_r;
    hand_nxt        = hand_r;
    filled_nxt      = filled_r;
    fault_total_nxt = fault_total_r;
    seek_nxt        = seek_r;
    tgt_nxt         = tgt_r;
    vict_nxt        = vict_r;
    vidx_nxt        = vidx_r;
    old_rank_nxt    = old_rank_r;
    clr_nxt         = clr_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;

    if (accept) begin
      page_nxt = in_page;
    end

    unique case (state_r)
      prfe_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = prfe_pkg::ST_SEL;
        end
      end
      prfe_pkg::ST_SEL: begin
        if (sel_done) begin
          state_nxt    = prfe_pkg::ST_APPLY;
          seek_nxt     = 1'b0;
          kind_nxt     = kind_sel;
          vict_nxt     = vict_sel;
          vidx_nxt     = vidx_sel;
          old_rank_nxt = old_rank_sel;
          clr_nxt      = (is_fault && (policy_r == prfe_pkg::POL_CLOCK)) ?
                         clk_clr_vec : '0;
        end else begin
          seek_nxt = 1'b1;
          tgt_nxt  = tgt - IDX_W'(1);
        end
      end
      prfe_pkg::ST_APPLY: begin
        if (apply_go) begin
          state_nxt = accept ? prfe_pkg::ST_SEL : prfe_pkg::ST_IDLE;
          unique case (kind_r)
            prfe_pkg::KIND_FILL: filled_nxt = filled_r + CNT_W'(1);
            prfe_pkg::KIND_FAULT: begin
              if (policy_r == prfe_pkg::POL_LRU) begin
                hand_nxt = hand_eff;
              end else begin
                hand_nxt = (vnext >= eff) ? '0 : IDX_W'(vnext);
              end
              if (fault_total_r != '1) begin
                fault_total_nxt = fault_total_r + prfe_pkg::COUNT_W'(1);
              end
            end
            default: ;
          endcase
          out_valid_nxt         = 1'b1;
          out_nxt.hit           = (kind_r == prfe_pkg::KIND_HIT);
          out_nxt.fault         = (kind_r == prfe_pkg::KIND_FAULT);
          out_nxt.written       = (kind_r != prfe_pkg::KIND_HIT);
          out_nxt.slot          = prfe_pkg::SLOT_W'(vidx_r);
          out_nxt.evicted_valid = (kind_r == prfe_pkg::KIND_FAULT);
          out_nxt.evicted_page  = (kind_r == prfe_pkg::KIND_FAULT) ?
                                  prfe_pkg::PAGE_W'(ev_page) : '0;
          out_nxt.fault_count   = fault_total_nxt;
          out_nxt.frames_used   = prfe_pkg::USED_W'(filled_nxt);
        end
      end
      default: state_nxt = prfe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= prfe_pkg::ST_IDLE;
      policy_r      <= prfe_pkg::POL_FIFO;
      fc_r          <= prfe_pkg::FC_RESET;
      hand_r        <= '0;
      filled_r      <= '0;
      fault_total_r <= '0;
      seek_r        <= 1'b0;
      kind_r        <= prfe_pkg::KIND_HIT;
      vict_r        <= '0;
      clr_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      policy_r      <= policy_nxt;
      fc_r          <= fc_nxt;
      hand_r        <= hand_nxt;
      filled_r      <= filled_nxt;
      fault_total_r <= fault_total_nxt;
      seek_r        <= seek_nxt;
      kind_r        <= kind_nxt;
      vict_r        <= vict_nxt;
      clr_r         <= clr_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r     <= page_nxt;
    tgt_r      <= tgt_nxt;
    vidx_r     <= vidx_nxt;
    old_rank_r <= old_rank_nxt;
    out_r      <= out_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // ------------------------------------------------------------ assertions
  a_vict_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == prfe_pkg::ST_APPLY |-> $onehot(vict_r))
    else $error("victim select is not one-hot at commit");

  a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(filled_r) <= CNT_W'(FRAMES))
    else $error("filled frame count past the built frame count");

  a_accept_to_sel: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r == prfe_pkg::ST_SEL)
    else $error("accepted beat did not enter victim select");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.hit && out_r.fault) && (out_r.hit != out_r.written))
    else $error("result flags inconsistent");

  a_fill_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    apply_go && kind_r == prfe_pkg::KIND_FILL |=> fault_total_r == $past(fault_total_r))
    else $error("fill phase miss changed the fault count");

endmodule

FILE: rtl/prfe_cell.sv
// prfe_cell: one page frame (tag, recency rank, used bit) with its tag compare
// and its stage of the second-chance search chain. Depends on prfe_pkg.
module prfe_cell #(
  parameter int IDX       = 0,
  parameter int PAGE_BITS = 16,
  parameter int IDX_W     = 4,
  parameter int CNT_W     = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  prfe_pkg::cell_cmd_t    cmd,
  input  logic [PAGE_BITS-1:0]   cmp_page,
  input  logic [PAGE_BITS-1:0]   wr_page,
  input  logic                   fwd_hit,
  input  logic [CNT_W-1:0]       filled,
  input  logic [CNT_W-1:0]       eff,
  input  logic [CNT_W-1:0]       old_rank,
  input  logic [IDX_W-1:0]       hand,
  input  logic [IDX_W-1:0]       tgt,
  input  logic                   vict,
  input  logic                   clr,
  input  prfe_pkg::clk_chain_t   chain_in,
  input  logic                   any_a,
  output prfe_pkg::clk_chain_t   chain_out,
  output logic                   match,
  output logic                   cand,
  output logic                   clk_sel,
  output logic                   clk_clr,
  output logic [PAGE_BITS-1:0]   tag,
  output logic [IDX_W-1:0]       rank
);

  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [PAGE_BITS-1:0] tag_r, tag_nxt;
  logic [IDX_W-1:0]     rank_r, rank_nxt;
  logic                 used_r, used_nxt;
  logic                 match_r, match_nxt;
  logic                 valid, en, free, in_a, in_b;

  assign valid = MY_CNT < filled;
  assign en    = MY_CNT < eff;
  assign free  = en && !used_r;
  assign in_a  = MY_IDX >= hand;
  assign in_b  = !in_a;

  // first free frame at/after the hand, else first free frame before it
  assign chain_out.found_a = chain_in.found_a | (free & in_a);
  assign chain_out.found_b = chain_in.found_b | (free & in_b);
  assign clk_sel = (free & in_a & !chain_in.found_a) |
                   (!any_a & free & in_b & !chain_in.found_b);
  // frames the hand sweeps past lose their second chance
  assign clk_clr = en & ((in_a & !chain_out.found_a) |
                         (!any_a & in_b & !chain_out.found_b));

  assign cand  = en && (rank_r == tgt);
  assign match = match_r;
  assign tag   = tag_r;
  assign rank  = rank_r;

  always_comb begin
    tag_nxt   = tag_r;
    rank_nxt  = rank_r;
    used_nxt  = used_r;
    match_nxt = match_r;
    if (cmd.load) begin
      // the frame being rewritten this cycle compares against the new page
      if (cmd.apply && vict && cmd.write_tag) begin
        match_nxt = fwd_hit;
      end else begin
        match_nxt = valid && (tag_r == cmp_page);
      end
    end
    if (cmd.apply) begin
      if (vict) begin
        rank_nxt = '0;
        used_nxt = 1'b1;
        if (cmd.write_tag) begin
          tag_nxt = wr_page;
        end
      end else begin
        if (valid && (CNT_W'(rank_r) < old_rank)) begin
          rank_nxt = rank_r + IDX_W'(1);
        end
        if (clr) begin
          used_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r  <= '0;
      used_r  <= 1'b0;
      match_r <= 1'b0;
    end else begin
      rank_r  <= rank_nxt;
      used_r  <= used_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

endmodule
